// ===== hw/rtl/sdae_pkg.sv =====
// Package for the signed decimal ASCII emitter.
// Holds widths, character codes, the converter result type and the BCD adjust function.
// No dependencies.
`timescale 1ns / 1ps

package sdae_pkg;

    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int SHIFT_CNT_W = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(BCD_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic             neg;
    } conv_res_t;

    // Add-3 step of the shift-and-add-3 conversion, applied to one BCD digit.
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        logic [3:0] r;
        begin
            r = (d >= 4'd5) ? d + 4'd3 : d;
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/sdae_bcd_conv.sv =====
// Bit-serial binary to BCD converter (shift-and-add-3), one magnitude bit per cycle.
// Depends on sdae_pkg.
`timescale 1ns / 1ps

module sdae_bcd_conv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [sdae_pkg::VALUE_W-1:0] value,
    output logic                       res_valid,
    input  logic                       res_take,
    output sdae_pkg::conv_res_t        res
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_DONE  = 3'b100
    } conv_state_t;

    conv_state_t                          state_reg, state_next;
    logic [sdae_pkg::SHIFT_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [sdae_pkg::VALUE_W-1:0]         mag_reg, mag_next;
    logic [sdae_pkg::BCD_W-1:0]           bcd_reg, bcd_next;
    logic                                 neg_reg, neg_next;
    logic [sdae_pkg::BCD_W-1:0]           bcd_adj;
    logic                                 accept;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        for (int i = 0; i < sdae_pkg::BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = sdae_pkg::bcd_adjust(bcd_reg[4*i +: 4]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = value[sdae_pkg::VALUE_W-1];
                    // The most negative value negates to itself, which is its
                    // correct unsigned magnitude.
                    mag_next   = value[sdae_pkg::VALUE_W-1] ?
                                 (~value + 1'b1) : value;
                    bcd_next   = '0;
                    cnt_next   = '1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                bcd_next = {bcd_adj[sdae_pkg::BCD_W-2:0], mag_reg[sdae_pkg::VALUE_W-1]};
                mag_next = {mag_reg[sdae_pkg::VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign res_valid = (state_reg == ST_DONE);
    assign res.bcd   = bcd_reg;
    assign res.neg   = neg_reg;

    a_accept_starts_shift: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SHIFT) && (cnt_reg == '1))
        else $error("accepted transaction did not start the shift sequence");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_take |=> res_valid && $stable(res))
        else $error("converter result changed before it was taken");

    a_digits_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (bcd_reg[3:0] <= 4'd9) && (bcd_reg[39:36] <= 4'd2))
        else $error("converter produced a digit out of range");

    a_mag_drained: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (mag_reg == '0))
        else $error("conversion finished with magnitude bits left");

endmodule

// ===== hw/rtl/sdae_emit.sv =====
// Character emitter: strips leading zero digits and sends sign and digits one per transaction.
// Depends on sdae_pkg.
`timescale 1ns / 1ps

module sdae_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    output logic                res_take,
    input  sdae_pkg::conv_res_t res,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          ascii_char,
    output logic                last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TRIM = 3'b010,
        ST_EMIT = 3'b100
    } emit_state_t;

    emit_state_t                        state_reg, state_next;
    logic [sdae_pkg::BCD_W-1:0]         dig_reg, dig_next;
    logic [sdae_pkg::DIG_CNT_W-1:0]     ndig_reg, ndig_next;
    logic                               neg_reg, neg_next;
    logic                               out_valid_reg, out_valid_next;
    logic [7:0]                         char_reg, char_next;
    logic                               last_reg, last_next;
    logic [3:0]                         top_dig;
    logic                               out_free;

    assign top_dig  = dig_reg[sdae_pkg::BCD_W-1 -: 4];
    assign out_free = !out_valid_reg || !out_stall;
    assign res_take = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        dig_next       = dig_reg;
        ndig_next      = ndig_reg;
        neg_next       = neg_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (res_valid)
                begin
                    dig_next   = res.bcd;
                    neg_next   = res.neg;
                    ndig_next  = sdae_pkg::DIG_CNT_W'(sdae_pkg::BCD_DIGITS);
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                // Drop one leading zero per cycle, always keeping the last digit.
                if (top_dig == 4'd0 && ndig_reg != sdae_pkg::DIG_CNT_W'(1))
                begin
                    dig_next  = {dig_reg[sdae_pkg::BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        char_next = sdae_pkg::CHAR_MINUS;
                        last_next = 1'b0;
                        neg_next  = 1'b0;
                    end
                    else
                    begin
                        char_next = sdae_pkg::CHAR_ZERO + {4'd0, top_dig};
                        last_next = (ndig_reg == sdae_pkg::DIG_CNT_W'(1));
                        dig_next  = {dig_reg[sdae_pkg::BCD_W-5:0], 4'd0};
                        ndig_next = ndig_reg - 1'b1;
                        if (ndig_reg == sdae_pkg::DIG_CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        ndig_reg <= ndig_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ascii_char == sdae_pkg::CHAR_MINUS) ||
                      (ascii_char >= sdae_pkg::CHAR_ZERO &&
                       ascii_char <= sdae_pkg::CHAR_ZERO + 8'd9))
        else $error("emitted character is neither a sign nor a digit");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ascii_char == sdae_pkg::CHAR_MINUS) |-> !last)
        else $error("sign character flagged as last");

    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRIM) || (state_reg == ST_EMIT) |-> (ndig_reg != '0))
        else $error("emitter busy with no digits left");

    a_last_ends_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_free && (state_reg == ST_EMIT) && !neg_reg &&
        (ndig_reg == sdae_pkg::DIG_CNT_W'(1)) |=> (state_reg == ST_IDLE) && last)
        else $error("final digit did not end the number");

endmodule

// ===== hw/rtl/signed_decimal_ascii_emitter_top.sv =====
// Top level of the signed decimal ASCII emitter.
// Depends on sdae_pkg, sdae_bcd_conv and sdae_emit.
`timescale 1ns / 1ps

// Each accepted 32-bit signed value is emitted as decimal ASCII text, most
// significant digit first, with a leading '-' for negative values; zero gives
// a single '0', and last marks the final character of each number. The
// converter shifts one magnitude bit per cycle through a ten-digit BCD
// register and holds the finished digits until the emitter, when idle, takes
// them. The emitter then drops up to nine leading zeros at one digit per cycle
// and sends one character per cycle, while the output does not stall, through
// a registered output (1 to 11 characters). The converter accepts no new value
// until its result is taken, but takes the next value while the previous one
// is still being emitted; output stalls that keep the emitter busy leave the
// converter's result waiting and so stall new values too.
module signed_decimal_ascii_emitter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sdae_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          ascii_char,
    output logic                                last
);

    sdae_pkg::conv_res_t conv_res;
    logic                conv_valid;
    logic                conv_take;

    sdae_bcd_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .res_valid (conv_valid),
        .res_take  (conv_take),
        .res       (conv_res)
    );

    sdae_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (conv_valid),
        .res_take   (conv_take),
        .res        (conv_res),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

endmodule

// ===== tb/sdae_checker.sv =====
// Checker for the signed decimal ASCII emitter: predicts the characters of each
// accepted value and compares them, in order, with the characters the block emits.
// Depends on sdae_pkg for the value width and the character codes.
`timescale 1ns / 1ps

module sdae_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [sdae_pkg::VALUE_W-1:0] value,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [7:0]                          ascii_char,
    input  logic                                last,
    output int                                  mismatches,
    output int                                  pending
);

    localparam int RADIX      = 10;
    localparam int MAX_DIGITS = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } text_char_t;

    text_char_t expected_chars[$];
    int         error_total = 0;

    // Appends the decimal text of one value, sign first, to the expected characters.
    function automatic void push_decimal_text(input logic [sdae_pkg::VALUE_W-1:0] raw);
        logic [sdae_pkg::VALUE_W-1:0] mag;
        logic [3:0]                   digs[MAX_DIGITS];
        int                           nd;
        text_char_t                   c;
        begin
            nd = 0;
            // Two's complement negation in 32 unsigned bits keeps the full
            // magnitude of the most negative value.
            if (raw[sdae_pkg::VALUE_W-1])
            begin
                mag       = ~raw + 1'b1;
                c.ch      = sdae_pkg::CHAR_MINUS;
                c.is_last = 1'b0;
                expected_chars.push_back(c);
            end
            else
            begin
                mag = raw;
            end
            do
            begin
                digs[nd] = 4'(mag % RADIX);
                mag      = mag / RADIX;
                nd++;
            end while (mag != 0 && nd < MAX_DIGITS);
            for (int i = nd - 1; i >= 0; i--)
            begin
                c.ch      = sdae_pkg::CHAR_ZERO + 8'(digs[i]);
                c.is_last = (i == 0);
                expected_chars.push_back(c);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t exp_c;
        if (!rst_n)
        begin
            expected_chars.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                push_decimal_text(value);
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("ascii_char: unexpected character 0x%02h with nothing pending",
                           ascii_char);
                    error_total++;
                end
                else
                begin
                    exp_c = expected_chars.pop_front();
                    if (ascii_char !== exp_c.ch)
                    begin
                        $error("ascii_char: expected 0x%02h, actual 0x%02h",
                               exp_c.ch, ascii_char);
                        error_total++;
                    end
                    if (last !== exp_c.is_last)
                    begin
                        $error("last: expected %0b, actual %0b", exp_c.is_last, last);
                        error_total++;
                    end
                end
            end
            pending    <= expected_chars.size();
            mismatches <= error_total;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the signed decimal ASCII emitter: clock, reset, value stimulus,
// output stall pattern, watchdog and verdict.
// Depends on sdae_pkg, signed_decimal_ascii_emitter_top and sdae_checker.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_PER_PHASE = 130;
    localparam longint POS_MAX    = 64'd2147483647;
    localparam longint NEG_MAX    = 64'd2147483648;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic signed [sdae_pkg::VALUE_W-1:0] value = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [7:0]                          ascii_char;
    logic                                last;
    int                                  mismatches;
    int                                  pending;
    int                                  in_idle_pct = 25;
    int                                  out_stall_pct = 87;
    int                                  quiet_cycles = 0;

    signed_decimal_ascii_emitter_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

    sdae_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ascii_char (ascii_char),
        .last       (last),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Presents one value and holds it until the block takes it.
    task automatic send_value(input logic [sdae_pkg::VALUE_W-1:0] v);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random value weighted toward every digit count, trailing zeros and the extremes.
    function automatic logic [sdae_pkg::VALUE_W-1:0] pick_value();
        int                           kind;
        int                           nd;
        logic                         neg;
        longint                       lo;
        longint                       hi;
        longint                       cap;
        longint                       mag;
        logic [sdae_pkg::VALUE_W-1:0] m32;
        begin
            kind = $urandom_range(9);
            neg  = 1'($urandom_range(1));
            cap  = neg ? NEG_MAX : POS_MAX;
            if (kind < 2)
                return $urandom;
            if (kind < 7)
            begin
                nd = $urandom_range(10, 1);
                lo = 1;
                repeat (nd - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (nd == 1)
                    lo = 0;
                if (hi > cap)
                    hi = cap;
                mag = lo + longint'($urandom_range(32'(hi - lo)));
            end
            else if (kind < 9)
            begin
                mag = $urandom_range(9, 1);
                repeat ($urandom_range(9))
                    if (mag * 10 <= cap)
                        mag = mag * 10;
            end
            else
            begin
                mag = cap - longint'($urandom_range(3));
            end
            m32 = mag[sdae_pkg::VALUE_W-1:0];
            return neg ? (~m32 + 1'b1) : m32;
        end
    endfunction

    task automatic run_random(input int count);
        repeat (count)
            send_value(pick_value());
    endtask

    initial
    begin
        logic [sdae_pkg::VALUE_W-1:0] directed[$];
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd100,
                     -32'sd100, 32'd1000, 32'd999999999, 32'd1000000000,
                     32'd2000000000, 32'd123456789, -32'sd987654321,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'd4294967, -32'sd9};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles now and then, receiver stalls most of the time.
        foreach (directed[i])
            send_value(directed[i]);
        run_random(RANDOM_PER_PHASE);

        in_idle_pct   = 87;
        out_stall_pct = 25;
        run_random(RANDOM_PER_PHASE);

        in_idle_pct   = 0;
        out_stall_pct = 0;
        run_random(RANDOM_PER_PHASE);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
